/* rtl/core/tar_pkg.sv */
// Shared types, constants and helper functions of the timed axis-angle rotation core.
`default_nettype none

package tar_pkg;

  localparam int CORDIC_STAGES = 16;

  // Angle in Q.16 radians after speed * elapsed, and its split into bytes.
  localparam int ANG_W  = 56;
  localparam int NCHUNK = ANG_W / 8;

  // Width of the CORDIC datapath and of the folded angle, Q.30.
  localparam int CW = 34;
  // Width of the wide folding arithmetic.
  localparam int ZW = 35;

  localparam logic [18:0] TWO_PI_Q16 = 19'd411775;

  // Quotient estimate for the modulo: floor(s * MOD_RECIP / 2^MOD_SHIFT).
  localparam int          MOD_SHIFT = 48;
  localparam logic [29:0] MOD_RECIP = 30'((64'd1 << MOD_SHIFT) / 64'd411775);
  localparam int          Q_W       = 12;

  localparam logic signed [ZW-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [ZW-1:0] TWO_PI_Q30  = 35'sd6746518852;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [ZW-1:0] ONE_Q30     = 35'sd1073741824;
  localparam logic signed [CW-1:0] GAIN_Q30    = 34'sd652032874;

  // atan(2^-i) in Q.30, truncated.
  localparam logic [29:0] ATAN_Q30 [31] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
    30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
    30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
    30'd127, 30'd63, 30'd31, 30'd15, 30'd8, 30'd4, 30'd2, 30'd1
  };

  typedef struct packed {
    logic        [47:0] sim_time;
    logic        [47:0] start_time;
    logic signed [23:0] ang_speed;
    logic signed [31:0] orbit_duration;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } req_t;

  // Everything the output stages need besides cosine and sine.
  typedef struct packed {
    logic               expired;
    logic signed [15:0] kx;
    logic signed [15:0] ky;
    logic signed [15:0] kz;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [31:0] crx;
    logic signed [31:0] cry;
    logic signed [31:0] crz;
    logic signed [31:0] dot;
  } side_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 neg;
    side_t                side;
  } cord_t;

  // 2^e modulo two pi in Q.16, evaluated at elaboration.
  function automatic logic [18:0] pow2_mod(input int e);
    logic [19:0] acc;
    acc = 20'd1;
    for (int i = 0; i < e; i++) begin
      acc = acc << 1;
      if (acc >= 20'(TWO_PI_Q16)) begin
        acc = acc - 20'(TWO_PI_Q16);
      end
    end
    return acc[18:0];
  endfunction

  localparam logic [19:0] SIGN_CORR = 20'(TWO_PI_Q16) - 20'(pow2_mod(ANG_W));

  function automatic logic signed [47:0] mul_kv(input logic signed [15:0] k,
                                                input logic signed [31:0] v);
    logic signed [47:0] ke;
    logic signed [47:0] ve;
    ke = 48'(k);
    ve = 48'(v);
    return ke * ve;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [71:0] a);
    if (a > 72'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (a < -72'sd2147483648) begin
      return 32'sh80000000;
    end
    return a[31:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/tar_front.sv */
// Front pipeline: elapsed time, expiry, angle, modulo two pi, fold, cross and dot products.
`default_nettype none

module tar_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  tar_pkg::req_t  in_req,
  output logic           out_valid,
  output tar_pkg::cord_t out_data
);
  import tar_pkg::*;

  // Stage 1: elapsed time.
  logic               f1_valid;
  logic signed [48:0] f1_elapsed;
  req_t               f1_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (en) begin
      f1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_elapsed <= $signed({1'b0, in_req.sim_time}) - $signed({1'b0, in_req.start_time});
      f1_req     <= in_req;
    end
  end

  // Stage 2: partial products of speed * elapsed, expiry, axis by position products.
  logic signed [48:0] spd_x;
  logic signed [48:0] eh_x;
  logic signed [48:0] el_x;
  logic signed [48:0] dur_x;

  assign spd_x = 49'(f1_req.ang_speed);
  assign eh_x  = 49'($signed(f1_elapsed[48:24]));
  assign el_x  = $signed({25'd0, f1_elapsed[23:0]});
  assign dur_x = 49'(f1_req.orbit_duration);

  logic               f2_valid;
  logic signed [48:0] f2_ph;
  logic signed [48:0] f2_pl;
  logic               f2_expired;
  logic signed [15:0] f2_kx, f2_ky, f2_kz;
  logic signed [31:0] f2_vx, f2_vy, f2_vz;
  logic signed [47:0] f2_xy, f2_yx, f2_yz, f2_zy, f2_zx, f2_xz, f2_xx, f2_yy, f2_zz;

  always_ff @(posedge clk) begin
    if (rst) begin
      f2_valid <= 1'b0;
    end else if (en) begin
      f2_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2_ph      <= spd_x * eh_x;
      f2_pl      <= spd_x * el_x;
      f2_expired <= (f1_req.orbit_duration > 32'sd0) && (f1_elapsed >= dur_x);
      f2_kx      <= f1_req.axis_x;
      f2_ky      <= f1_req.axis_y;
      f2_kz      <= f1_req.axis_z;
      f2_vx      <= f1_req.pos_x;
      f2_vy      <= f1_req.pos_y;
      f2_vz      <= f1_req.pos_z;
      f2_xy      <= mul_kv(f1_req.axis_x, f1_req.pos_y);
      f2_yx      <= mul_kv(f1_req.axis_y, f1_req.pos_x);
      f2_yz      <= mul_kv(f1_req.axis_y, f1_req.pos_z);
      f2_zy      <= mul_kv(f1_req.axis_z, f1_req.pos_y);
      f2_zx      <= mul_kv(f1_req.axis_z, f1_req.pos_x);
      f2_xz      <= mul_kv(f1_req.axis_x, f1_req.pos_z);
      f2_xx      <= mul_kv(f1_req.axis_x, f1_req.pos_x);
      f2_yy      <= mul_kv(f1_req.axis_y, f1_req.pos_y);
      f2_zz      <= mul_kv(f1_req.axis_z, f1_req.pos_z);
    end
  end

  // Stage 3: angle and saturated cross and dot products.
  logic signed [56:0] ph_ext;
  logic signed [56:0] pl_ext;
  logic signed [56:0] ang_full;
  logic signed [71:0] d_x, d_y, d_z, d_dot;

  assign ph_ext   = $signed({f2_ph, 8'd0});
  assign pl_ext   = 57'(f2_pl);
  assign ang_full = ph_ext + (pl_ext >>> 16);
  assign d_x      = (72'(f2_yz) - 72'(f2_zy)) >>> 14;
  assign d_y      = (72'(f2_zx) - 72'(f2_xz)) >>> 14;
  assign d_z      = (72'(f2_xy) - 72'(f2_yx)) >>> 14;
  assign d_dot    = (72'(f2_xx) + 72'(f2_yy) + 72'(f2_zz)) >>> 14;

  logic             f3_valid;
  logic [ANG_W-1:0] f3_ang;
  side_t            f3_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      f3_valid <= 1'b0;
    end else if (en) begin
      f3_valid <= f2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f3_ang          <= ang_full[ANG_W-1:0];
      f3_side.expired <= f2_expired;
      f3_side.kx      <= f2_kx;
      f3_side.ky      <= f2_ky;
      f3_side.kz      <= f2_kz;
      f3_side.vx      <= f2_vx;
      f3_side.vy      <= f2_vy;
      f3_side.vz      <= f2_vz;
      f3_side.crx     <= sat32(d_x);
      f3_side.cry     <= sat32(d_y);
      f3_side.crz     <= sat32(d_z);
      f3_side.dot     <= sat32(d_dot);
    end
  end

  // Stage 4: byte-wise sum congruent to the angle modulo two pi. A set sign bit takes
  // 2^ANG_W off the unsigned value, made up for by a positive correction modulo two pi.
  logic [29:0] chunk_prod [NCHUNK];
  logic [29:0] s_sum;

  for (genvar g = 0; g < NCHUNK; g++) begin : g_chunk
    localparam logic [18:0] WEIGHT = pow2_mod(8 * g);
    assign chunk_prod[g] = 30'(f3_ang[8*g +: 8]) * 30'(WEIGHT);
  end

  always_comb begin
    s_sum = f3_ang[ANG_W-1] ? 30'(SIGN_CORR) : 30'd0;
    for (int i = 0; i < NCHUNK; i++) begin
      s_sum = s_sum + chunk_prod[i];
    end
  end

  logic        f4_valid;
  logic [29:0] f4_s;
  side_t       f4_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      f4_valid <= 1'b0;
    end else if (en) begin
      f4_valid <= f3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f4_s    <= s_sum;
      f4_side <= f3_side;
    end
  end

  // Stage 5: quotient estimate by reciprocal, low by at most one.
  logic [59:0] q_prod;

  assign q_prod = 60'(f4_s) * 60'(MOD_RECIP);

  logic           f5_valid;
  logic [Q_W-1:0] f5_q;
  logic [29:0]    f5_s;
  side_t          f5_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      f5_valid <= 1'b0;
    end else if (en) begin
      f5_valid <= f4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f5_q    <= q_prod[MOD_SHIFT +: Q_W];
      f5_s    <= f4_s;
      f5_side <= f4_side;
    end
  end

  // Stage 6: remainder with one correction step.
  logic [29:0] qm;
  logic [29:0] r_full;
  logic [29:0] r_fix;

  assign qm     = 30'(f5_q) * 30'(TWO_PI_Q16);
  assign r_full = f5_s - qm;
  assign r_fix  = (r_full >= 30'(TWO_PI_Q16)) ? r_full - 30'(TWO_PI_Q16) : r_full;

  logic        f6_valid;
  logic [18:0] f6_r;
  side_t       f6_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      f6_valid <= 1'b0;
    end else if (en) begin
      f6_valid <= f5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f6_r    <= r_fix[18:0];
      f6_side <= f5_side;
    end
  end

  // Stage 7: scale to Q.30 and fold into [-pi/2, pi/2].
  logic signed [ZW-1:0] z0;
  logic signed [ZW-1:0] z1;
  logic signed [ZW-1:0] z2;
  logic                 fold;

  always_comb begin
    z0   = $signed({2'b00, f6_r, 14'd0});
    z1   = (z0 > PI_Q30) ? z0 - TWO_PI_Q30 : z0;
    z2   = z1;
    fold = 1'b0;
    if (z1 > HALF_PI_Q30) begin
      z2   = z1 - PI_Q30;
      fold = 1'b1;
    end else if (z1 < -HALF_PI_Q30) begin
      z2   = z1 + PI_Q30;
      fold = 1'b1;
    end
  end

  logic                 f7_valid;
  logic signed [CW-1:0] f7_z;
  logic                 f7_neg;
  side_t                f7_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      f7_valid <= 1'b0;
    end else if (en) begin
      f7_valid <= f6_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f7_z    <= z2[CW-1:0];
      f7_neg  <= fold;
      f7_side <= f6_side;
    end
  end

  assign out_valid     = f7_valid;
  assign out_data.x    = GAIN_Q30;
  assign out_data.y    = '0;
  assign out_data.z    = f7_z;
  assign out_data.neg  = f7_neg;
  assign out_data.side = f7_side;

`ifndef ASSERT_OFF
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    f6_valid |-> (f6_r < TWO_PI_Q16))
    else $error("angle remainder not below two pi");

  a_fold_range: assert property (@(posedge clk) disable iff (rst)
    f7_valid |-> (ZW'(f7_z) <= HALF_PI_Q30) && (ZW'(f7_z) >= -HALF_PI_Q30))
    else $error("folded angle outside half pi");
`endif

endmodule

`default_nettype wire

/* rtl/core/tar_cordic.sv */
// Pipelined rotation-mode CORDIC, one micro-rotation per register stage.
`default_nettype none

module tar_cordic (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  tar_pkg::cord_t in_data,
  output logic           out_valid,
  output tar_pkg::cord_t out_data
);
  import tar_pkg::*;

  cord_t                    st  [CORDIC_STAGES];
  logic [CORDIC_STAGES-1:0] vld;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
    localparam logic signed [CW-1:0] ANGLE = $signed({4'd0, ATAN_Q30[g]});
    cord_t                cur;
    logic                 cur_v;
    cord_t                nxt;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;

    if (g == 0) begin : g_first
      assign cur   = in_data;
      assign cur_v = in_valid;
    end else begin : g_rest
      assign cur   = st[g-1];
      assign cur_v = vld[g-1];
    end

    assign dx = cur.y >>> g;
    assign dy = cur.x >>> g;

    always_comb begin
      nxt = cur;
      if (cur.z >= 0) begin
        nxt.x = cur.x - dx;
        nxt.y = cur.y + dy;
        nxt.z = cur.z - ANGLE;
      end else begin
        nxt.x = cur.x + dx;
        nxt.y = cur.y - dy;
        nxt.z = cur.z + ANGLE;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (en) begin
        vld[g] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[g] <= nxt;
      end
    end
  end

  assign out_valid = vld[CORDIC_STAGES-1];
  assign out_data  = st[CORDIC_STAGES-1];

endmodule

`default_nettype wire

/* rtl/core/tar_back.sv */
// Back pipeline: sign of cosine and sine, Rodrigues terms, sum, saturation and result register.
`default_nettype none

module tar_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  tar_pkg::cord_t     in_data,
  output logic               out_valid,
  output logic signed [31:0] rot_x,
  output logic signed [31:0] rot_y,
  output logic signed [31:0] rot_z,
  output logic               expired
);
  import tar_pkg::*;

  // Stage 1: undo the fold.
  logic                 b1_valid;
  logic signed [CW-1:0] b1_c;
  logic signed [CW-1:0] b1_s;
  side_t                b1_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else if (en) begin
      b1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_c    <= in_data.neg ? -in_data.x : in_data.x;
      b1_s    <= in_data.neg ? -in_data.y : in_data.y;
      b1_side <= in_data.side;
    end
  end

  // Stage 2: v*c, (k x v)*s and (k.v)*(1-c).
  logic signed [31:0]   v  [3];
  logic signed [31:0]   cr [3];
  logic signed [ZW-1:0] omc;
  logic signed [71:0]   dd_full;
  logic signed [71:0]   t1_full [3];
  logic signed [71:0]   t2_full [3];

  assign v[0]  = b1_side.vx;
  assign v[1]  = b1_side.vy;
  assign v[2]  = b1_side.vz;
  assign cr[0] = b1_side.crx;
  assign cr[1] = b1_side.cry;
  assign cr[2] = b1_side.crz;
  assign omc   = ONE_Q30 - ZW'(b1_c);
  assign dd_full = (72'(b1_side.dot) * 72'(omc)) >>> 30;

  for (genvar j = 0; j < 3; j++) begin : g_term
    assign t1_full[j] = (72'(v[j]) * 72'(b1_c)) >>> 30;
    assign t2_full[j] = (72'(cr[j]) * 72'(b1_s)) >>> 30;
  end

  logic               b2_valid;
  logic signed [31:0] b2_dd;
  logic signed [35:0] b2_t1 [3];
  logic signed [35:0] b2_t2 [3];
  side_t              b2_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      b2_valid <= 1'b0;
    end else if (en) begin
      b2_valid <= b1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b2_dd   <= sat32(dd_full);
      b2_side <= b1_side;
      for (int j = 0; j < 3; j++) begin
        b2_t1[j] <= t1_full[j][35:0];
        b2_t2[j] <= t2_full[j][35:0];
      end
    end
  end

  // Stage 3: axis term, sum and saturate; an expired orbit passes the position through.
  logic signed [15:0] k  [3];
  logic signed [31:0] pv [3];
  logic signed [71:0] t3_full [3];
  logic signed [71:0] sum [3];
  logic signed [31:0] res [3];

  assign k[0]  = b2_side.kx;
  assign k[1]  = b2_side.ky;
  assign k[2]  = b2_side.kz;
  assign pv[0] = b2_side.vx;
  assign pv[1] = b2_side.vy;
  assign pv[2] = b2_side.vz;

  for (genvar j = 0; j < 3; j++) begin : g_sum
    assign t3_full[j] = (72'(b2_dd) * 72'(k[j])) >>> 14;
    assign sum[j]     = 72'(b2_t1[j]) + 72'(b2_t2[j]) + t3_full[j];
    assign res[j]     = b2_side.expired ? pv[j] : sat32(sum[j]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= b2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_x   <= res[0];
      rot_y   <= res[1];
      rot_z   <= res[2];
      expired <= b2_side.expired;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/timed_axis_angle_rotation_core.sv */
// Top level of the timed axis-angle rotation core: input skid register and pipeline.
//
// One request carries an entity's simulation time, orbit creation time, angular
// speed, orbit duration, unit rotation axis and position. The core computes the
// elapsed time; if a positive duration has run out the position comes back
// unchanged with expired set, otherwise it is rotated about the axis by the angle
// speed * elapsed (reduced modulo two pi) using Rodrigues' formula.
// Both channels use valid and stall; a transfer happens on a rising edge where
// valid is high and stall is low. Each request yields exactly one result, in order.
// From acceptance to res_valid a request passes through seven front stages, then
// one stage per CORDIC micro-rotation and three back stages ending in the result
// register. A new request is taken every cycle while the receiver takes results.
// When res_stall holds a pending result, the whole pipeline freezes in place; the
// one request that arrives in that cycle is caught by a skid register, and
// req_stall rises the cycle after, straight from that register. Synchronous reset
// clears all valid bits and the skid register; data registers are not reset.
`default_nettype none

module timed_axis_angle_rotation_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic        [47:0] sim_time,
  input  logic        [47:0] start_time,
  input  logic signed [23:0] ang_speed,
  input  logic signed [31:0] orbit_duration,
  input  logic signed [15:0] axis_x,
  input  logic signed [15:0] axis_y,
  input  logic signed [15:0] axis_z,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  output logic               res_valid,
  input  logic               res_stall,
  output logic signed [31:0] rot_x,
  output logic signed [31:0] rot_y,
  output logic signed [31:0] rot_z,
  output logic               expired
);
  import tar_pkg::*;

  // The pipeline advances whenever the result register is empty or being taken.
  logic en;
  assign en = !(res_valid && res_stall);

  req_t port_req;
  assign port_req.sim_time       = sim_time;
  assign port_req.start_time     = start_time;
  assign port_req.ang_speed      = ang_speed;
  assign port_req.orbit_duration = orbit_duration;
  assign port_req.axis_x         = axis_x;
  assign port_req.axis_y         = axis_y;
  assign port_req.axis_z         = axis_z;
  assign port_req.pos_x          = pos_x;
  assign port_req.pos_y          = pos_y;
  assign port_req.pos_z          = pos_z;

  // Skid register: holds a request accepted in a cycle where the pipeline is frozen.
  // While it is full the port is stalled, and it drains first once the pipeline moves.
  logic skid_full;
  req_t skid;

  assign req_stall = skid_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (en) begin
      skid_full <= 1'b0;
    end else if (req_valid && !skid_full) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && !skid_full && req_valid) begin
      skid <= port_req;
    end
  end

  logic src_valid;
  req_t src_req;
  assign src_valid = skid_full || req_valid;
  assign src_req   = skid_full ? skid : port_req;

  logic  front_valid;
  cord_t front_data;
  logic  cordic_valid;
  cord_t cordic_data;

  tar_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (src_valid),
    .in_req    (src_req),
    .out_valid (front_valid),
    .out_data  (front_data)
  );

  tar_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (front_valid),
    .in_data   (front_data),
    .out_valid (cordic_valid),
    .out_data  (cordic_data)
  );

  tar_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (cordic_valid),
    .in_data   (cordic_data),
    .out_valid (res_valid),
    .rot_x     (rot_x),
    .rot_y     (rot_y),
    .rot_z     (rot_z),
    .expired   (expired)
  );

`ifndef ASSERT_OFF
  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    skid_full && !en |=> skid_full)
    else $error("skid request dropped while pipeline frozen");

  a_skid_catch: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && !en |=> skid_full)
    else $error("request accepted during freeze not captured");

  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    skid_full && en |=> !skid_full)
    else $error("skid request not drained when pipeline advanced");
`endif

endmodule

`default_nettype wire

/* test/tb_timed_axis_angle_rotation_core.sv */
// Self-checking testbench for the timed axis-angle rotation core.
`timescale 1ns / 100ps

module tb_timed_axis_angle_rotation_core;
  import tar_pkg::*;

  // The result of one rotation request as the core should report it.
  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               ended;
  } rot_t;

  // One request to send.
  // A typed row carries its own hand-written answer instead of the predicted one.
  typedef struct {
    req_t r;
    bit   typed;
    rot_t want;
  } orbit_req_t;

  localparam int RANDOM_REQS = 1600;
  localparam int CYCLE_LIMIT = 400000;
  // Requests with an index in this range go out with neither side idling.
  localparam int CALM_FIRST  = 1000;
  localparam int CALM_LAST   = 1300;
  // Once this many requests have been accepted, the receiver holds off for a long stretch.
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 300;
  // At this request index the sender waits until every result has come back.
  localparam int DRAIN_AT    = 800;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  logic [47:0] sim_time = '0;
  logic [47:0] start_time = '0;
  logic signed [23:0] ang_speed = '0;
  logic signed [31:0] orbit_duration = '0;
  logic signed [15:0] axis_x = '0;
  logic signed [15:0] axis_y = '0;
  logic signed [15:0] axis_z = '0;
  logic signed [31:0] pos_x = '0;
  logic signed [31:0] pos_y = '0;
  logic signed [31:0] pos_z = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  logic signed [31:0] rot_x;
  logic signed [31:0] rot_y;
  logic signed [31:0] rot_z;
  logic expired;

  orbit_req_t orbit_reqs[$];
  rot_t       pending_rots[$];
  orbit_req_t on_wire;
  int         next_req = 0;
  int         accepted = 0;
  int         fails = 0;
  int         cycles = 0;
  bit         drain_done = 0;
  bit         hold_used = 0;
  int         hold_left = 0;

  timed_axis_angle_rotation_core uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .sim_time(sim_time), .start_time(start_time), .ang_speed(ang_speed),
    .orbit_duration(orbit_duration),
    .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .res_valid(res_valid), .res_stall(res_stall),
    .rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z), .expired(expired)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint clamp32(input longint a);
    if (a > 64'sd2147483647) begin
      return 64'sd2147483647;
    end
    if (a < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return a;
  endfunction

  // Rotates the request position about its axis by speed * elapsed.
  // All shifts are arithmetic, so they round toward minus infinity.
  // An orbit whose positive duration has run out passes the position through.
  function automatic rot_t rotate_entity(input req_t r);
    longint el, lo, hi, spd, ang, rr, z, x, y, t, dx, dy, c, s, dot, dd;
    longint k[3];
    longint v[3];
    longint cr[3];
    longint res[3];
    bit     neg;
    rot_t   o;
    k[0] = longint'(r.axis_x);
    k[1] = longint'(r.axis_y);
    k[2] = longint'(r.axis_z);
    v[0] = longint'(r.pos_x);
    v[1] = longint'(r.pos_y);
    v[2] = longint'(r.pos_z);
    el = longint'({16'd0, r.sim_time}) - longint'({16'd0, r.start_time});
    if (r.orbit_duration > 0 && el >= longint'(r.orbit_duration)) begin
      o.x = r.pos_x;
      o.y = r.pos_y;
      o.z = r.pos_z;
      o.ended = 1'b1;
      return o;
    end
    // The angle is built in two halves so that no product overflows.
    spd = longint'(r.ang_speed);
    lo = el & 64'hFFFFFF;
    hi = el >>> 24;
    ang = spd * hi * 256 + ((spd * lo) >>> 16);
    // Reduce the angle into [0, 2pi), move it to Q.30, then fold it into
    // [-pi/2, pi/2]. A fold by pi flips the sign of cosine and sine.
    rr = ang % longint'(TWO_PI_Q16);
    if (rr < 0) begin
      rr = rr + longint'(TWO_PI_Q16);
    end
    z = rr * 16384;
    neg = 0;
    if (z > longint'(PI_Q30)) begin
      z = z - 2 * longint'(PI_Q30);
    end
    if (z > longint'(HALF_PI_Q30)) begin
      z = z - longint'(PI_Q30);
      neg = 1;
    end else if (z < -longint'(HALF_PI_Q30)) begin
      z = z + longint'(PI_Q30);
      neg = 1;
    end
    x = longint'(GAIN_Q30);
    y = 0;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        t = x - dx;
        y = y + dy;
        z = z - longint'(ATAN_Q30[i]);
      end else begin
        t = x + dx;
        y = y - dy;
        z = z + longint'(ATAN_Q30[i]);
      end
      x = t;
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
    // Rodrigues: v*c + (k x v)*s + k*(k.v)*(1-c).
    cr[0] = clamp32((k[1] * v[2] - k[2] * v[1]) >>> 14);
    cr[1] = clamp32((k[2] * v[0] - k[0] * v[2]) >>> 14);
    cr[2] = clamp32((k[0] * v[1] - k[1] * v[0]) >>> 14);
    dot = clamp32((k[0] * v[0] + k[1] * v[1] + k[2] * v[2]) >>> 14);
    dd = clamp32((dot * (longint'(ONE_Q30) - c)) >>> 30);
    for (int j = 0; j < 3; j++) begin
      res[j] = clamp32(((v[j] * c) >>> 30) + ((cr[j] * s) >>> 30) + ((dd * k[j]) >>> 14));
    end
    o.x = res[0][31:0];
    o.y = res[1][31:0];
    o.z = res[2][31:0];
    o.ended = 1'b0;
    return o;
  endfunction

  // Adds one request to the list that the sender walks through.
  task automatic add_req(input logic [47:0] st, input logic [47:0] born,
                         input logic signed [23:0] spd, input logic signed [31:0] dur,
                         input logic signed [15:0] kx, input logic signed [15:0] ky,
                         input logic signed [15:0] kz, input logic signed [31:0] px,
                         input logic signed [31:0] py, input logic signed [31:0] pz,
                         input bit typed, input bit ended_flag);
    orbit_req_t q;
    q.r.sim_time = st;
    q.r.start_time = born;
    q.r.ang_speed = spd;
    q.r.orbit_duration = dur;
    q.r.axis_x = kx;
    q.r.axis_y = ky;
    q.r.axis_z = kz;
    q.r.pos_x = px;
    q.r.pos_y = py;
    q.r.pos_z = pz;
    q.typed = typed;
    // Typed rows are expired orbits: the position must come back as it went in.
    q.want.x = px;
    q.want.y = py;
    q.want.z = pz;
    q.want.ended = ended_flag;
    orbit_reqs.push_back(q);
  endtask

  function automatic logic [47:0] rand48();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[47:0];
  endfunction

  function automatic logic signed [15:0] rand_axis();
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  // Build the full request list.
  // The directed part is a table of corner cases; the random part comes after it.
  initial begin
    logic [47:0] born, st;
    logic signed [31:0] dur, px, py, pz;
    logic signed [15:0] kx, ky, kz;
    int sel;
    // sim_time, start_time, speed, duration, axis x/y/z, pos x/y/z, typed, expired
    // An expired orbit passes extreme positions through untouched.
    add_req(48'd100 << 16, 48'd0, 24'sd65536, 32'sd65536, 16'sd0, 16'sd0, 16'sd16384,
            32'sh7fffffff, 32'sh80000000, 32'sd0, 1, 1);
    // Elapsed time exactly equal to the duration already counts as expired.
    add_req(48'd5 << 16, 48'd3 << 16, -24'sd1, 32'sd131072, 16'sd1, 16'sd2, 16'sd3,
            -32'sd1, 32'sd1, 32'sd7, 1, 1);
    // The largest elapsed time against the largest duration is expired as well.
    add_req({48{1'b1}}, 48'd0, 24'sh7fffff, 32'sh7fffffff, -16'sd16384, 16'sd0, 16'sd0,
            32'sd12345, -32'sd54321, 32'sd0, 1, 1);
    // One tick short of the duration, the orbit is still live.
    add_req(48'd5 << 16, 48'd3 << 16, 24'sd65536, 32'sd131073, 16'sd0, 16'sd0, 16'sd16384,
            32'sd65536, 32'sd0, 32'sd0, 0, 0);
    // Endless orbits with a duration of zero, the most negative value and minus one.
    add_req(48'd0, 48'd0, 24'sd0, 32'sd0, 16'sd0, 16'sd0, 16'sd16384,
            32'sd65536, 32'sd131072, 32'sd196608, 0, 0);
    add_req({48{1'b1}}, 48'd0, 24'sh7fffff, 32'sh80000000, 16'sd16384, 16'sd0, 16'sd0,
            32'sd1000, 32'sd2000, 32'sd3000, 0, 0);
    add_req({48{1'b1}}, 48'd0, 24'sh800000, -32'sd1, 16'sd0, 16'sd16384, 16'sd0,
            32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0);
    // Time before creation gives a negative elapsed time and a negative angle.
    add_req(48'd0, {48{1'b1}}, 24'sh800000, 32'sd65536, 16'sd0, 16'sd0, 16'sd16384,
            32'sh80000000, 32'sh7fffffff, 32'sd0, 0, 0);
    add_req(48'd1 << 16, 48'd2 << 16, 24'sd102944, 32'sd0, 16'sd9459, 16'sd9459, 16'sd9459,
            32'sd65536, -32'sd65536, 32'sd65536, 0, 0);
    // Extreme axes that are not unit length, with extreme positions, to drive saturation.
    add_req(48'd3 << 16, 48'd0, 24'sd205887, 32'sd0, -16'sd16384, -16'sd16384, -16'sd16384,
            32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0, 0);
    add_req(48'd7 << 16, 48'd0, 24'sd51472, 32'sd0, 16'sd16384, 16'sd16384, 16'sd16384,
            32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 0, 0);
    add_req(48'd1, 48'd0, 24'sd1, 32'sd0, 16'sd0, 16'sd0, 16'sd0,
            32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0);
    // Angles of about a quarter and half turn, which fall on the fold points.
    add_req(48'd1 << 16, 48'd0, 24'sd102944, 32'sd0, 16'sd0, 16'sd0, 16'sd16384,
            32'sd65536, 32'sd0, 32'sd0, 0, 0);
    add_req(48'd1 << 16, 48'd0, 24'sd205888, 32'sd0, 16'sd0, 16'sd0, 16'sd16384,
            32'sd65536, 32'sd65536, 32'sd0, 0, 0);

    for (int n = 0; n < RANDOM_REQS; n++) begin
      born = rand48();
      sel = $urandom_range(0, 9);
      // Most requests sit from four seconds before to 36 seconds after the creation time; some are wild.
      if (sel < 7) begin
        st = born + 48'($signed($urandom_range(0, 40 << 16)) - (4 << 16));
      end else begin
        st = rand48();
      end
      sel = $urandom_range(0, 9);
      if (sel < 3) begin
        dur = (sel == 0) ? 32'sd0 : -32'($urandom_range(1, 32'h7fffffff));
      end else if (sel < 9) begin
        dur = 32'($urandom_range(1, 30 << 16));
      end else begin
        dur = 32'($urandom());
      end
      if ($urandom_range(0, 1)) begin
        // A unit axis along one coordinate, either sign.
        kx = 16'sd0;
        ky = 16'sd0;
        kz = 16'sd0;
        sel = $urandom_range(0, 2);
        if (sel == 0) kx = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
        if (sel == 1) ky = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
        if (sel == 2) kz = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
      end else begin
        kx = rand_axis();
        ky = rand_axis();
        kz = rand_axis();
      end
      if ($urandom_range(0, 2) == 0) begin
        px = 32'($urandom());
        py = 32'($urandom());
        pz = 32'($urandom());
      end else begin
        px = 32'($signed($urandom_range(0, 200 << 16)) - (100 << 16));
        py = 32'($signed($urandom_range(0, 200 << 16)) - (100 << 16));
        pz = 32'($signed($urandom_range(0, 200 << 16)) - (100 << 16));
      end
      add_req(st, born, 24'($urandom()), dur, kx, ky, kz, px, py, pz, 0, 0);
    end
  end

  // Reset, then wait for every request to be answered.
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (accepted < orbit_reqs.size() || pending_rots.size() != 0) begin
      @(posedge clk);
    end
    // Give a stray extra result time to show up past the pipeline depth.
    repeat (CORDIC_STAGES + 30) @(posedge clk);
    if (fails == 0) begin
      $display("timed_axis_angle_rotation_core verification clean");
    end else begin
      $display("timed_axis_angle_rotation_core verification failed");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timed_axis_angle_rotation_core verification failed");
      $finish;
    end
  end

  function automatic bit calm_zone();
    return next_req >= CALM_FIRST && next_req <= CALM_LAST;
  endfunction

  // Request sender.
  // A request that was accepted at this edge gets its expected result recorded.
  // A request that is still stalled stays on the wire unchanged.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) begin
        pending_rots.push_back(on_wire.typed ? on_wire.want : rotate_entity(on_wire.r));
        accepted++;
      end
      if (!req_valid || !req_stall) begin
        // At one point, hold back until every result has come back.
        if (next_req == DRAIN_AT && !drain_done && pending_rots.size() != 0) begin
          req_valid <= 1'b0;
        end else if (next_req < orbit_reqs.size() &&
                     (calm_zone() || $urandom_range(0, 99) >= 30)) begin
          if (next_req == DRAIN_AT) drain_done = 1;
          on_wire = orbit_reqs[next_req];
          next_req++;
          sim_time <= on_wire.r.sim_time;
          start_time <= on_wire.r.start_time;
          ang_speed <= on_wire.r.ang_speed;
          orbit_duration <= on_wire.r.orbit_duration;
          axis_x <= on_wire.r.axis_x;
          axis_y <= on_wire.r.axis_y;
          axis_z <= on_wire.r.axis_z;
          pos_x <= on_wire.r.pos_x;
          pos_y <= on_wire.r.pos_y;
          pos_z <= on_wire.r.pos_z;
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver.
  // It stalls at random, and once holds off long enough for the core to fill and
  // push back on the sender.
  always @(posedge clk) begin
    rot_t want;
    if (!rst) begin
      if (res_valid && !res_stall) begin
        if (pending_rots.size() == 0) begin
          $display("%0t: result with no request outstanding: x=%0d y=%0d z=%0d expired=%0b",
                   $time, rot_x, rot_y, rot_z, expired);
          fails++;
        end else begin
          want = pending_rots.pop_front();
          if (rot_x !== want.x) begin
            $display("%0t: rot_x expected %0d got %0d", $time, want.x, rot_x);
            fails++;
          end
          if (rot_y !== want.y) begin
            $display("%0t: rot_y expected %0d got %0d", $time, want.y, rot_y);
            fails++;
          end
          if (rot_z !== want.z) begin
            $display("%0t: rot_z expected %0d got %0d", $time, want.z, rot_z);
            fails++;
          end
          if (expired !== want.ended) begin
            $display("%0t: expired expected %0b got %0b", $time, want.ended, expired);
            fails++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else if (!hold_used && accepted >= HOLD_AT) begin
        hold_used = 1;
        hold_left = HOLD_CYCLES;
        res_stall <= 1'b1;
      end else begin
        res_stall <= !calm_zone() && $urandom_range(0, 99) < 30;
      end
    end
  end

endmodule
